// ----- sv/modem_power_key_and_status_monitor_assert.svh -----
// Assertion macros used by the checker file of the power key and status monitor.
`ifndef MODEM_POWER_KEY_AND_STATUS_MONITOR_ASSERT_SVH
`define MODEM_POWER_KEY_AND_STATUS_MONITOR_ASSERT_SVH

// Property checked only outside reset.
`define MPKSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MPKSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mpksm_pkg.sv -----
// Types, register map and constants of the modem power key and status monitor.
`default_nettype none
package mpksm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEADY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PULSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] STEADY_RST    = 16'd900;
  localparam logic [CFG_W-1:0] LONG_HIGH_RST = 16'd700;
  localparam logic [CFG_W-1:0] LONG_LOW_RST  = 16'd750;
  localparam logic [CFG_W-1:0] BLINK_RST     = 16'd180;
  localparam logic [CFG_W-1:0] KEY_PULSE_RST = 16'd1500;
  localparam logic [CFG_W-1:0] RETRY_RST     = 16'd30000;

  // request opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_POWER_ON  = 2'd1;
  localparam logic [1:0] OP_POWER_OFF = 2'd2;

  // modem status codes
  localparam logic [1:0] ST_OFF        = 2'd0;
  localparam logic [1:0] ST_SLOW_BLINK = 2'd1;
  localparam logic [1:0] ST_FAST_BLINK = 2'd2;
  localparam logic [1:0] ST_STEADY_LOW = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       wwan_level;
  } in_item_t;

  typedef struct packed {
    logic       key_level;
    logic [1:0] modem_status;
    logic       step_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] steady_threshold;
    logic [CFG_W-1:0] long_high_threshold;
    logic [CFG_W-1:0] long_low_threshold;
    logic [CFG_W-1:0] blink_threshold;
    logic [CFG_W-1:0] key_pulse_ticks;
    logic [CFG_W-1:0] retry_ticks;
  } cfg_regs_t;

endpackage
`default_nettype wire

// ----- sv/mpksm_classifier.sv -----
// Status pin run timers and status classification.
`default_nettype none
module mpksm_classifier import mpksm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       wwan_level,
  input  wire cfg_regs_t  cfg,
  output logic [1:0]      status_nxt
);

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic [TIMER_WIDTH-1:0] low_run_r, low_run_nxt, high_run_r, high_run_nxt;
  logic                   low_valid_r, low_valid_nxt, high_valid_r, high_valid_nxt;
  logic [1:0]             status_r;
  logic [TIMER_WIDTH-1:0] low_adv, high_adv, low_el, high_el;

  always_comb begin
    // a run that is not active restarts at zero
    low_adv  = low_valid_r ? ((low_run_r == TMAX) ? low_run_r : low_run_r + 1'b1) : '0;
    high_adv = high_valid_r ? ((high_run_r == TMAX) ? high_run_r : high_run_r + 1'b1) : '0;
    // a cleared run reads as saturated
    low_el   = low_valid_r ? low_adv : TMAX;
    high_el  = high_valid_r ? high_adv : TMAX;

    status_nxt = status_r;
    if (!wwan_level) begin
      low_run_nxt    = low_adv;
      low_valid_nxt  = 1'b1;
      high_run_nxt   = '0;
      high_valid_nxt = 1'b0;
      if (CMP_W'(low_adv) >= CMP_W'(cfg.steady_threshold)) begin
        status_nxt = ST_STEADY_LOW;
      end else if (CMP_W'(high_el) >= CMP_W'(cfg.long_high_threshold)) begin
        status_nxt = ST_SLOW_BLINK;
      end else if (CMP_W'(high_el) >= CMP_W'(cfg.blink_threshold)) begin
        status_nxt = ST_FAST_BLINK;
      end else if (status_r == ST_OFF) begin
        status_nxt = ST_STEADY_LOW;
      end
    end else begin
      high_run_nxt   = high_adv;
      high_valid_nxt = 1'b1;
      low_run_nxt    = '0;
      low_valid_nxt  = 1'b0;
      if (CMP_W'(high_adv) >= CMP_W'(cfg.steady_threshold)) begin
        status_nxt = ST_OFF;
      end else if (CMP_W'(low_el) >= CMP_W'(cfg.long_low_threshold)) begin
        status_nxt = ST_SLOW_BLINK;
      end else if (CMP_W'(low_el) >= CMP_W'(cfg.blink_threshold)) begin
        status_nxt = ST_FAST_BLINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_run_r    <= '0;
      low_valid_r  <= 1'b0;
      high_run_r   <= '0;
      high_valid_r <= 1'b0;
      status_r     <= ST_OFF;
    end else if (en) begin
      low_run_r    <= low_run_nxt;
      low_valid_r  <= low_valid_nxt;
      high_run_r   <= high_run_nxt;
      high_valid_r <= high_valid_nxt;
      status_r     <= status_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mpksm_key_seq.sv -----
// Power key pulse and retry sequencing.
`default_nettype none
module mpksm_key_seq import mpksm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic [1:0] op,
  input  wire logic [1:0] status,
  input  wire cfg_regs_t  cfg,
  output logic            key_nxt,
  output logic            done_nxt
);

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic [TIMER_WIDTH-1:0] sh_r, sh_nxt, sl_r, sl_nxt;
  logic                   sh_valid_r, sh_valid_nxt, sl_valid_r, sl_valid_nxt;
  logic                   key_r;
  logic [TIMER_WIDTH-1:0] sh_adv, sl_adv, sh_el;
  logic                   step, target;

  always_comb begin
    sh_adv = (sh_valid_r && sh_r != TMAX) ? sh_r + 1'b1 : sh_r;
    sl_adv = (sl_valid_r && sl_r != TMAX) ? sl_r + 1'b1 : sl_r;
    sh_el  = sh_valid_r ? sh_adv : TMAX;

    case (op)
      OP_POWER_ON: begin
        step   = 1'b1;
        target = (status != ST_OFF);
      end
      OP_POWER_OFF: begin
        step   = 1'b1;
        target = (status == ST_OFF);
      end
      default: begin
        step   = 1'b0;
        target = 1'b0;
      end
    endcase

    sh_nxt       = sh_adv;
    sl_nxt       = sl_adv;
    sh_valid_nxt = sh_valid_r;
    sl_valid_nxt = sl_valid_r;
    key_nxt      = key_r;
    done_nxt     = 1'b0;

    if (step) begin
      if (target) begin
        sh_nxt       = '0;
        sh_valid_nxt = 1'b0;
        sl_nxt       = '0;
        sl_valid_nxt = 1'b0;
        key_nxt      = 1'b0;
        done_nxt     = 1'b1;
      end else if (key_r) begin
        if (CMP_W'(sh_el) > CMP_W'(cfg.key_pulse_ticks)) begin
          sl_nxt       = '0;
          sl_valid_nxt = 1'b1;
          key_nxt      = 1'b0;
        end
      end else if (!sl_valid_r || CMP_W'(sl_adv) > CMP_W'(cfg.retry_ticks)) begin
        // first pulse, or retry after the release wait
        sh_nxt       = '0;
        sh_valid_nxt = 1'b1;
        key_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r       <= '0;
      sh_valid_r <= 1'b0;
      sl_r       <= '0;
      sl_valid_r <= 1'b0;
      key_r      <= 1'b0;
    end else if (en) begin
      sh_r       <= sh_nxt;
      sh_valid_r <= sh_valid_nxt;
      sl_r       <= sl_nxt;
      sl_valid_r <= sl_valid_nxt;
      key_r      <= key_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/modem_power_key_and_status_monitor.sv -----
// Top level of the modem power key and status monitor.
// Each request is one millisecond tick carrying the sampled WWAN status pin and an
// optional power-on or power-off step; each gives exactly one result with the key
// pin level, the classified modem status and a done flag. The block takes one
// request per clock while results are taken: the request lands in an input
// register, the run and key timers, threshold compares and key step are one pass
// of compare logic, and the result is held in an output register until taken.
// While a result is stalled, one more request can still enter the input register;
// after that the input stalls too. Timers saturate at 2^TIMER_WIDTH - 1. The user
// must write configuration via the cfg_ port only while no request is in flight;
// the block does not enforce this. Indexes past the last register are ignored.
`default_nettype none
module modem_power_key_and_status_monitor import mpksm_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  in_item_t  in_data_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  cfg_regs_t cfg_r;
  logic      adv, en;
  logic [1:0] status_nxt;
  logic      key_nxt, done_nxt;

  assign adv          = !out_valid_r || out_ready;
  assign en           = in_valid_r && adv;
  assign in_ready     = !in_valid_r || adv;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !adv);
  assign out_valid_nxt = en || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (en) begin
      out_data_r.key_level    <= key_nxt;
      out_data_r.modem_status <= status_nxt;
      out_data_r.step_done    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steady_threshold    <= STEADY_RST;
      cfg_r.long_high_threshold <= LONG_HIGH_RST;
      cfg_r.long_low_threshold  <= LONG_LOW_RST;
      cfg_r.blink_threshold     <= BLINK_RST;
      cfg_r.key_pulse_ticks     <= KEY_PULSE_RST;
      cfg_r.retry_ticks         <= RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEADY:    cfg_r.steady_threshold    <= cfg_wdata;
        CFG_LONG_HIGH: cfg_r.long_high_threshold <= cfg_wdata;
        CFG_LONG_LOW:  cfg_r.long_low_threshold  <= cfg_wdata;
        CFG_BLINK:     cfg_r.blink_threshold     <= cfg_wdata;
        CFG_KEY_PULSE: cfg_r.key_pulse_ticks     <= cfg_wdata;
        CFG_RETRY:     cfg_r.retry_ticks         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mpksm_classifier #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_classifier (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .wwan_level (in_data_r.wwan_level),
    .cfg        (cfg_r),
    .status_nxt (status_nxt)
  );

  // key step sees the status already updated by this tick's pin sample
  mpksm_key_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_key_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .op       (in_data_r.op),
    .status   (status_nxt),
    .cfg      (cfg_r),
    .key_nxt  (key_nxt),
    .done_nxt (done_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/mpksm_checker.sv -----
// Port-level checks for the modem power key and status monitor, with its bind.
`default_nettype none
`include "modem_power_key_and_status_monitor_assert.svh"
module mpksm_checker import mpksm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // no result may appear right after reset
  `MPKSM_ASSERT_ALWAYS(a_no_out_after_rst, clk, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result holds
  `MPKSM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // a completed step always leaves the key released
  `MPKSM_ASSERT(a_done_key_low, clk, rst_n, out_valid && out_data.step_done |-> !out_data.key_level, "step done with key high")

  // with the output free the block must take a request
  `MPKSM_ASSERT(a_ready_when_free, clk, rst_n, !out_valid |-> in_ready, "not ready while output empty")

endmodule

bind modem_power_key_and_status_monitor mpksm_checker u_mpksm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
